[rtl/ddo_pkg.sv]
// Shared types and constants for the differential-drive odometry core.
// No dependencies.
`timescale 1ns / 1ps

package ddo_pkg;

  localparam int unsigned CNT_W     = 6;   // holds step counts up to MUL_B_W
  localparam int unsigned MUL_A_W   = 64;
  localparam int unsigned MUL_B_W   = 52;
  localparam int unsigned ACC_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned CW        = 34;  // CORDIC datapath width
  localparam int unsigned DT_W      = 21;
  localparam int unsigned T_W       = 52;

  localparam logic [20:0] DT_LIMIT   = 21'd1048576;
  localparam logic [41:0] HEAD_SCALE = 42'd2935890503282;
  localparam logic [30:0] US_RECIP   = 31'd1125899907;
  localparam logic [31:0] IBW_RESET  = 32'd655360;
  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [CW-1:0] Q30_ONE      = 34'sd1073741824;

  // operand bit counts of the serial multiplier, per operation
  localparam logic [CNT_W-1:0] N_W   = 6'd32;
  localparam logic [CNT_W-1:0] N_HW1 = 6'd21;
  localparam logic [CNT_W-1:0] N_HW2 = 6'd42;
  localparam logic [CNT_W-1:0] N_T   = 6'd21;
  localparam logic [CNT_W-1:0] N_P1  = 6'd31;
  localparam logic [CNT_W-1:0] N_P2  = 6'd52;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_W,
    ST_HW1,
    ST_HW2,
    ST_T,
    ST_COR1,
    ST_PX1,
    ST_PX2,
    ST_PY1,
    ST_PY2,
    ST_COR2,
    ST_OUT
  } state_e;

  function automatic logic [31:0] abs32(input logic signed [31:0] a);
    abs32 = a[31] ? (32'd0 - a) : a;
  endfunction

endpackage

[rtl/diff_drive_odometry_core.sv]
// Differential-drive dead-reckoning odometry core: top level.
// Uses ddo_pkg (types, constants, arctangent table).
`timescale 1ns / 1ps

// Usage:
//   Input stream s_axis: one word per wheel sample (left/right speed, Q16.16,
//   and a 48-bit microsecond timestamp). Output stream m_axis: one word per
//   sample with pose, heading, speeds and yaw quaternion.
//   cfg_we_i/cfg_wdata_i write the inverse base width; write only while idle.
// Timing:
//   Each sample is worked through a radix-2 shift-add multiplier that runs
//   eight products one after another, one operand bit per cycle, plus two
//   passes through a single CORDIC rotator, one step per cycle. A new sample
//   is accepted only after the previous one has left the sequencer:
//   s_axis_tready_o is high only while the sequencer is idle.
// Reset:
//   Pose, heading, timestamp history and the output valid clear; the inverse
//   base width returns to 10.0. The first sample after reset has dt = 0.
// Stall:
//   The result sits in an output register. The next sample is accepted
//   meanwhile; if it finishes before the old word is taken, it waits in the
//   final state until the output register frees.
module diff_drive_odometry_core #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,     // inverse_base_width
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [31:0] left_wheel_velocity, [63:32] right_wheel_velocity,
  // [111:64] sample_time_us
  input  logic [111:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] position_x, [63:32] position_y, [95:64] heading_angle,
  // [127:96] linear_speed, [159:128] angular_speed, [191:160] quat_z,
  // [223:192] quat_w
  output logic [223:0] m_axis_tdata_o
);

  localparam int unsigned AW = ddo_pkg::MUL_A_W;
  localparam int unsigned BW = ddo_pkg::MUL_B_W;
  localparam int unsigned PW = ddo_pkg::ACC_W;
  localparam int unsigned CW = ddo_pkg::CW;
  localparam int unsigned NW = ddo_pkg::CNT_W;

  ddo_pkg::state_e state_q, state_d;

  logic [31:0]          ibw_q;
  logic signed [31:0]   pose_x_q, pose_y_q;
  logic [31:0]          heading_q;
  logic [47:0]          prev_time_q;
  logic                 have_prev_q;
  logic signed [31:0]   v_q, w_q, cos_q, sin_q, hz_q;
  logic                 diff_neg_q;
  logic [20:0]          dt_q;
  logic [51:0]          t_q;
  logic [NW-1:0]        cnt_q;
  logic [AW-1:0]        mul_a_q;
  logic [BW-1:0]        mul_b_q;
  logic [PW-1:0]        acc_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic [1:0]           cq_q;
  logic                 out_valid_q;
  logic [223:0]         out_data_q;

  // ---------------- input decode ----------------
  logic signed [31:0] in_left, in_right;
  logic [47:0]        in_now, dt_raw;
  logic [20:0]        dt_new;
  logic signed [32:0] lr_sum, lr_diff;
  logic [32:0]        diff_mag;
  logic               in_acc;

  assign in_left  = s_axis_tdata_i[31:0];
  assign in_right = s_axis_tdata_i[63:32];
  assign in_now   = s_axis_tdata_i[111:64];
  assign dt_raw   = in_now - prev_time_q;
  assign lr_sum   = 33'(in_left) + 33'(in_right);
  assign lr_diff  = 33'(in_right) - 33'(in_left);
  assign diff_mag = lr_diff[32] ? (33'd0 - lr_diff) : lr_diff;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (!have_prev_q) begin
      dt_new = '0;
    end else if (dt_raw > 48'(ddo_pkg::DT_LIMIT)) begin
      dt_new = ddo_pkg::DT_LIMIT;
    end else begin
      dt_new = dt_raw[20:0];
    end
  end

  // ---------------- shared serial multiplier ----------------
  logic [PW-1:0] acc_step;
  assign acc_step = {acc_q[PW-2:0], 1'b0} + (mul_b_q[BW-1] ? PW'(mul_a_q) : '0);

  // ---------------- CORDIC rotator ----------------
  logic [4:0]           csh;
  logic signed [CW-1:0] cdx, cdy, catan;
  logic signed [CW-1:0] cx_step, cy_step, cz_step;
  assign csh   = cnt_q[4:0];
  assign cdx   = cy_q >>> csh;
  assign cdy   = cx_q >>> csh;
  assign catan = CW'(ddo_pkg::ATAN_TAB[csh]);

  always_comb begin
    if (!cz_q[CW-1]) begin
      cx_step = cx_q - cdx;
      cy_step = cy_q + cdy;
      cz_step = cz_q - catan;
    end else begin
      cx_step = cx_q + cdx;
      cy_step = cy_q - cdy;
      cz_step = cz_q + catan;
    end
  end

  // start values for a new angle (quarter-turn reduction)
  logic [31:0]        cang, cang_sum, cang_red;
  logic [1:0]         cq_init;
  assign cang     = (state_q == ddo_pkg::ST_T) ? heading_q : {1'b0, heading_q[31:1]};
  assign cang_sum = cang + 32'h2000_0000;
  assign cq_init  = cang_sum[31:30];
  assign cang_red = cang - {cq_init, 30'd0};

  // rotate back and clamp
  logic signed [CW-1:0] rc, rs;
  logic signed [31:0]   cos_s, sin_s;
  always_comb begin
    unique case (cq_q)
      2'd1:    begin rc = -cy_q; rs = cx_q;  end
      2'd2:    begin rc = -cx_q; rs = -cy_q; end
      2'd3:    begin rc = cy_q;  rs = -cx_q; end
      default: begin rc = cx_q;  rs = cy_q;  end
    endcase
  end

  function automatic logic signed [31:0] clamp_q30(input logic signed [CW-1:0] a);
    if (a > ddo_pkg::Q30_ONE) begin
      clamp_q30 = 32'sd1073741824;
    end else if (a < -ddo_pkg::Q30_ONE) begin
      clamp_q30 = -32'sd1073741824;
    end else begin
      clamp_q30 = a[31:0];
    end
  endfunction

  assign cos_s = clamp_q30(rc);
  assign sin_s = clamp_q30(rs);

  // ---------------- result shaping ----------------
  logic [47:0]        w_m;
  logic signed [31:0] w_new;
  assign w_m = acc_q[63:16];
  always_comb begin
    if (diff_neg_q) begin
      w_new = (w_m > 48'd2147483648) ? 32'sh8000_0000 : 32'(48'd0 - w_m);
    end else begin
      w_new = (w_m > 48'd2147483647) ? 32'sh7FFF_FFFF : w_m[31:0];
    end
  end

  logic [31:0] hstep;
  assign hstep = acc_q[79:48];

  // position step and saturating add
  logic [35:0]        pstep;
  logic               pneg;
  logic signed [31:0] pose_cur, pose_new;
  logic signed [37:0] pose_sum, pstep_s;
  assign pstep    = acc_q[115:80];
  assign pneg     = (state_q == ddo_pkg::ST_PX2) ? (v_q[31] != cos_q[31])
                                                 : (v_q[31] != sin_q[31]);
  assign pose_cur = (state_q == ddo_pkg::ST_PX2) ? pose_x_q : pose_y_q;
  assign pstep_s  = pneg ? (38'sd0 - $signed({2'b00, pstep})) : $signed({2'b00, pstep});
  assign pose_sum = 38'(pose_cur) + pstep_s;
  always_comb begin
    if (pose_sum > 38'sd2147483647) begin
      pose_new = 32'sh7FFF_FFFF;
    end else if (pose_sum < -38'sd2147483648) begin
      pose_new = 32'sh8000_0000;
    end else begin
      pose_new = pose_sum[31:0];
    end
  end

  // ---------------- sequencer: outputs ----------------
  logic [NW-1:0] n_steps;
  logic          op_done;
  logic          out_free;

  always_comb begin
    unique case (state_q)
      ddo_pkg::ST_W:                   n_steps = ddo_pkg::N_W;
      ddo_pkg::ST_HW1:                 n_steps = ddo_pkg::N_HW1;
      ddo_pkg::ST_HW2:                 n_steps = ddo_pkg::N_HW2;
      ddo_pkg::ST_T:                   n_steps = ddo_pkg::N_T;
      ddo_pkg::ST_PX1, ddo_pkg::ST_PY1: n_steps = ddo_pkg::N_P1;
      ddo_pkg::ST_PX2, ddo_pkg::ST_PY2: n_steps = ddo_pkg::N_P2;
      ddo_pkg::ST_COR1, ddo_pkg::ST_COR2: n_steps = NW'(CORDIC_STEPS);
      default:                         n_steps = '0;
    endcase
  end

  always_comb begin
    out_free        = !out_valid_q || m_axis_tready_i;
    op_done         = (cnt_q == n_steps);
    s_axis_tready_o = (state_q == ddo_pkg::ST_IDLE);
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ddo_pkg::ST_IDLE: if (s_axis_tvalid_i) state_d = ddo_pkg::ST_W;
      ddo_pkg::ST_W:    if (op_done) state_d = ddo_pkg::ST_HW1;
      ddo_pkg::ST_HW1:  if (op_done) state_d = ddo_pkg::ST_HW2;
      ddo_pkg::ST_HW2:  if (op_done) state_d = ddo_pkg::ST_T;
      ddo_pkg::ST_T:    if (op_done) state_d = ddo_pkg::ST_COR1;
      ddo_pkg::ST_COR1: if (op_done) state_d = ddo_pkg::ST_PX1;
      ddo_pkg::ST_PX1:  if (op_done) state_d = ddo_pkg::ST_PX2;
      ddo_pkg::ST_PX2:  if (op_done) state_d = ddo_pkg::ST_PY1;
      ddo_pkg::ST_PY1:  if (op_done) state_d = ddo_pkg::ST_PY2;
      ddo_pkg::ST_PY2:  if (op_done) state_d = ddo_pkg::ST_COR2;
      ddo_pkg::ST_COR2: if (op_done) state_d = ddo_pkg::ST_OUT;
      ddo_pkg::ST_OUT:  if (out_free) state_d = ddo_pkg::ST_IDLE;
      default:          state_d = ddo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddo_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ibw_q       <= ddo_pkg::IBW_RESET;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      heading_q   <= '0;
      prev_time_q <= '0;
      have_prev_q <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ibw_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        prev_time_q <= in_now;
        have_prev_q <= 1'b1;
        cnt_q       <= '0;
      end else if (state_q != ddo_pkg::ST_IDLE && state_q != ddo_pkg::ST_OUT) begin
        cnt_q <= op_done ? '0 : cnt_q + 1'b1;
      end
      if (state_q == ddo_pkg::ST_HW2 && op_done) begin
        heading_q <= w_q[31] ? (heading_q - hstep) : (heading_q + hstep);
      end
      if (state_q == ddo_pkg::ST_PX2 && op_done) begin
        pose_x_q <= pose_new;
      end
      if (state_q == ddo_pkg::ST_PY2 && op_done) begin
        pose_y_q <= pose_new;
      end
      if (state_q == ddo_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q        <= lr_sum[32:1];
      diff_neg_q <= lr_diff[32];
      dt_q       <= dt_new;
      acc_q      <= '0;
      mul_a_q    <= AW'(diff_mag);
      mul_b_q    <= {ibw_q, 20'd0};
    end
    unique case (state_q)
      ddo_pkg::ST_W, ddo_pkg::ST_HW1, ddo_pkg::ST_HW2, ddo_pkg::ST_T,
      ddo_pkg::ST_PX1, ddo_pkg::ST_PX2, ddo_pkg::ST_PY1, ddo_pkg::ST_PY2: begin
        if (!op_done) begin
          acc_q   <= acc_step;
          mul_b_q <= {mul_b_q[BW-2:0], 1'b0};
        end else begin
          acc_q <= '0;
          unique case (state_q)
            ddo_pkg::ST_W: begin
              w_q     <= w_new;
              mul_a_q <= AW'(ddo_pkg::abs32(w_new));
              mul_b_q <= {dt_q, 31'd0};
            end
            ddo_pkg::ST_HW1: begin
              mul_a_q <= AW'(acc_q[51:0]);
              mul_b_q <= {ddo_pkg::HEAD_SCALE, 10'd0};
            end
            ddo_pkg::ST_HW2: begin
              mul_a_q <= AW'(ddo_pkg::US_RECIP);
              mul_b_q <= {dt_q, 31'd0};
            end
            ddo_pkg::ST_T: begin
              t_q  <= acc_q[51:0];
              cq_q <= cq_init;
              cx_q <= ddo_pkg::CORDIC_START;
              cy_q <= '0;
              cz_q <= CW'($signed(cang_red));
            end
            ddo_pkg::ST_PX1, ddo_pkg::ST_PY1: begin
              mul_a_q <= acc_q[63:0];
              mul_b_q <= t_q;
            end
            ddo_pkg::ST_PX2: begin
              mul_a_q <= AW'(ddo_pkg::abs32(v_q));
              mul_b_q <= {ddo_pkg::abs32(sin_q), 20'd0} << 1;
            end
            default: begin  // ST_PY2: second rotation on the half heading
              cq_q <= cq_init;
              cx_q <= ddo_pkg::CORDIC_START;
              cy_q <= '0;
              cz_q <= CW'($signed(cang_red));
            end
          endcase
        end
      end
      ddo_pkg::ST_COR1, ddo_pkg::ST_COR2: begin
        if (!op_done) begin
          cx_q <= cx_step;
          cy_q <= cy_step;
          cz_q <= cz_step;
        end else if (state_q == ddo_pkg::ST_COR1) begin
          cos_q   <= cos_s;
          sin_q   <= sin_s;
          acc_q   <= '0;
          mul_a_q <= AW'(ddo_pkg::abs32(v_q));
          mul_b_q <= {ddo_pkg::abs32(cos_s), 20'd0} << 1;
        end else begin
          cos_q <= cos_s;  // quat_w
          hz_q  <= sin_s;
        end
      end
      ddo_pkg::ST_OUT: begin
        if (out_free) begin
          out_data_q <= {cos_q, hz_q, w_q, v_q, heading_q, pose_y_q, pose_x_q};
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // ---------------- assertions ----------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(BW))
    else $error("step counter out of range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ddo_pkg::ST_W && cnt_q == '0))
    else $error("accepted word did not start the sequencer");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ddo_pkg::ST_OUT && out_free) |=>
      (m_axis_tvalid_o && state_q == ddo_pkg::ST_IDLE))
    else $error("result not presented after final state");

  a_history_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(have_prev_q))
    else $error("timestamp history lost");

endmodule
